>>> hw/rtl/gcd_lcm_pkg.sv
// Shared constants for the divisor and multiple unit.
`default_nettype none
package gcd_lcm_pkg;

  // Operand width in use; bits of an operand at or above it are ignored (8..32).
  localparam int OPERAND_WIDTH = 32;
  localparam int LCM_WIDTH     = 2 * OPERAND_WIDTH;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

  // Port field widths, fixed by the interface.
  localparam int FIELD_WIDTH     = 32;
  localparam int LCM_FIELD_WIDTH = 64;
  localparam int IN_DATA_WIDTH   = 2 * FIELD_WIDTH;
  localparam int OUT_DATA_WIDTH  = FIELD_WIDTH + LCM_FIELD_WIDTH;

endpackage
`default_nettype wire

>>> hw/rtl/gcd_lcm_unit.sv
// Greatest common divisor and least common multiple of two unsigned operands.
//
// Each input word carries two operands; each result word carries their greatest
// common divisor, their least common multiple at double width, and a flag in
// tuser that is set when both operands are zero (divisor and multiple then read
// 0). The divisor comes from Euclid's remainder loop and the multiple is
// (a / gcd) * b. All arithmetic runs through one bit-serial restoring divider
// and one bit-serial shift-add multiplier, one bit per cycle. Euclid's loop
// takes k remainder steps, where k is at most about 1.44 * W for operand width
// W; zero or equal operands skip the divider and multiplier. One pair is
// processed at a time; the result register lets the next pair be accepted while
// a finished result waits.
`default_nettype none
module gcd_lcm_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [gcd_lcm_pkg::IN_DATA_WIDTH-1:0]  in_tdata,   // operand_a, operand_b
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [gcd_lcm_pkg::OUT_DATA_WIDTH-1:0]      out_tdata,  // gcd_value, lcm_value
  output logic                                        out_tuser   // lcm_undefined
);

  localparam int W  = gcd_lcm_pkg::OPERAND_WIDTH;
  localparam int LW = gcd_lcm_pkg::LCM_WIDTH;
  localparam int CW = gcd_lcm_pkg::CNT_WIDTH;
  localparam int FW = gcd_lcm_pkg::FIELD_WIDTH;
  localparam int LF = gcd_lcm_pkg::LCM_FIELD_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EUCLID = 5'b00010,
    S_QUOT   = 5'b00100,
    S_MUL    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    hi_r, hi_nxt;
  logic [W-1:0]    lo_r, lo_nxt;
  logic [W-1:0]    dq_r, dq_nxt;
  logic [W-1:0]    drem_r, drem_nxt;
  logic [LW-1:0]   acc_r, acc_nxt;
  logic            undef_r, undef_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [FW-1:0]   out_gcd_r, out_gcd_nxt;
  logic [LF-1:0]   out_lcm_r, out_lcm_nxt;
  logic            out_undef_r, out_undef_nxt;

  logic [W-1:0]    op_a, op_b;
  logic [W-1:0]    div_d;
  logic [W:0]      rem_sh;
  logic            rem_ge;
  logic [W-1:0]    rem_new;
  logic [W-1:0]    q_new;
  logic            cnt_last;
  logic            accept;
  logic            out_free;

  assign op_a     = in_tdata[W-1:0];
  assign op_b     = in_tdata[FW+W-1:FW];
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_last = (cnt_r == CW'(W - 1));

  // One restoring divide step: divisor is lo in Euclid, the gcd (hi) for the quotient.
  assign div_d   = (state_r == S_QUOT) ? hi_r : lo_r;
  assign rem_sh  = {drem_r, dq_r[W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_d});
  assign rem_new = rem_ge ? W'(rem_sh - {1'b0, div_d}) : rem_sh[W-1:0];
  assign q_new   = {dq_r[W-2:0], rem_ge};

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    acc_nxt       = acc_r;
    undef_nxt     = undef_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_gcd_nxt   = out_gcd_r;
    out_lcm_nxt   = out_lcm_r;
    out_undef_nxt = out_undef_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt     = op_a;
          b_nxt     = op_b;
          undef_nxt = 1'b0;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          drem_nxt  = '0;
          hi_nxt    = (op_a > op_b) ? op_a : op_b;
          lo_nxt    = (op_a > op_b) ? op_b : op_a;
          dq_nxt    = (op_a > op_b) ? op_a : op_b;
          if (op_a == '0 && op_b == '0) begin
            undef_nxt = 1'b1;
            hi_nxt    = '0;
            state_nxt = S_DONE;
          end else if (op_a == op_b) begin
            hi_nxt    = op_a;
            acc_nxt   = LW'(op_a);
            state_nxt = S_DONE;
          end else if (op_a == '0 || op_b == '0) begin
            // gcd is the nonzero operand, multiple is zero
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_EUCLID;
          end
        end
      end
      S_EUCLID: begin
        dq_nxt   = q_new;
        drem_nxt = rem_new;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_last) begin
          cnt_nxt  = '0;
          drem_nxt = '0;
          hi_nxt   = lo_r;
          lo_nxt   = rem_new;
          if (rem_new == '0) begin
            // the old lo, now moved to hi, is the gcd; divide a by it next
            dq_nxt    = a_r;
            state_nxt = S_QUOT;
          end else begin
            dq_nxt = lo_r;
          end
        end
      end
      S_QUOT: begin
        dq_nxt   = q_new;
        drem_nxt = rem_new;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          lo_nxt    = q_new;
          dq_nxt    = b_r;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // MSB-first shift-add: acc = 2*acc + bit * quotient
        acc_nxt = {acc_r[LW-2:0], 1'b0} + (dq_r[W-1] ? LW'(lo_r) : LW'(0));
        dq_nxt  = {dq_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_gcd_nxt   = FW'(hi_r);
          out_lcm_nxt   = LF'(acc_r);
          out_undef_nxt = undef_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    acc_r       <= acc_nxt;
    undef_r     <= undef_nxt;
    out_gcd_r   <= out_gcd_nxt;
    out_lcm_r   <= out_lcm_nxt;
    out_undef_r <= out_undef_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_lcm_r, out_gcd_r};
  assign out_tuser  = out_undef_r;

endmodule
`default_nettype wire
